// ----- rtl/tsi_pkg.sv -----
// shared types and constants of the timestamp sync interpolator
// no dependencies; imported by the cell, the divider and the top level

package tsi_pkg;

   // register widths and indexes
   localparam int CFG_BITS    = 20;
   localparam int WARM_BITS   = 10;
   localparam int CSR_ADDR_W  = 2;
   localparam int STATUS_BITS = 3;

   localparam logic [CSR_ADDR_W-1:0] CFG_DELAY_TOL = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CFG_MAX_GAP   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CFG_WARMUP    = 2'd2;

   localparam logic [CFG_BITS-1:0]  TOL_RESET  = 20'd5000;
   localparam logic [CFG_BITS-1:0]  GAP_RESET  = 20'd10010;
   localparam logic [WARM_BITS-1:0] WARM_RESET = 10'd100;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_WARMUP    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_TIME_JUMP = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_DELAY     = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_NO_LATER  = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_GAP       = 3'd6;
   localparam logic [STATUS_BITS-1:0] ST_BEFORE    = 3'd7;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_MEDIAN,
      S_CHECK,
      S_COMMIT,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DIV,
      S_OUT
   } state_type;

   // per-cell control of the delay history chain
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

// ----- rtl/tsi_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies

module tsi_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/tsi_delay_cell.sv -----
// one cell of the line delay history chain: holds one signed delay,
// shifts from its neighbour, compares with a broadcast candidate; uses tsi_pkg

module tsi_delay_cell
   import tsi_pkg::*;
#(
   parameter int DW = 41
) (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic signed [DW-1:0] next_val,
   input  logic signed [DW-1:0] new_val,
   input  logic signed [DW-1:0] cand,
   output logic signed [DW-1:0] value,
   output logic                 lt,
   output logic                 eq
);

   logic signed [DW-1:0] value_ff;

   // load a new delay or take the neighbour's
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff <= new_val;
      end else if (ctrl.shift) begin
         value_ff <= next_val;
      end
   end

   // rank contribution against the candidate
   assign lt    = value_ff < cand;
   assign eq    = value_ff == cand;
   assign value = value_ff;

endmodule

// ----- rtl/tsi_muldiv.sv -----
// iterative round(m * a / b) with a < b, one bit of m per cycle
// fused shift-add multiply and restoring divide; uses tsi_pkg

module tsi_muldiv
   import tsi_pkg::*;
#(
   parameter int W = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] m,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic         done,
   output logic [W-1:0] result
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  m_ff, m_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W+1:0]  t_sum;
   logic [W+1:0]  b1_ext;
   logic [W+1:0]  b2_ext;
   logic [W:0]    quo_dbl;

   // one step: rem = 2 rem + bit * a, then take off b at most twice
   assign t_sum   = {1'b0, rem_ff, 1'b0} + (m_ff[W-1] ? {2'b00, a_ff} : '0);
   assign b1_ext  = {2'b00, b_ff};
   assign b2_ext  = {1'b0, b_ff, 1'b0};
   assign quo_dbl = {quo_ff, 1'b0};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      m_in    = m_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         m_in    = m;
         a_in    = a;
         b_in    = b;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         m_in   = {m_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (t_sum >= b2_ext) begin
            rem_in = W'(t_sum - b2_ext);
            quo_in = W'(quo_dbl + 2'd2);
         end else if (t_sum >= b1_ext) begin
            rem_in = W'(t_sum - b1_ext);
            quo_in = W'(quo_dbl + 2'd1);
         end else begin
            rem_in = W'(t_sum);
            quo_in = W'(quo_dbl);
         end
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      m_ff   <= m_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // round to nearest, halves away from zero
   assign done   = done_ff;
   assign result = quo_ff + W'({rem_ff, 1'b0} >= {1'b0, b_ff});

endmodule

// ----- rtl/timestamp_sync_interpolator.sv -----
// top level of the device-to-host timestamp mapper
// uses tsi_pkg, tsi_ram, tsi_delay_cell and tsi_muldiv

// One item is taken at a time and gives one result beat. A pair in warmup
// or a time jump goes from the decision straight to the output state, and a
// pair with a short delay history is stored first. With a full history,
// the median search walks the candidate cells of the delay chain one per
// cycle, up to HISTORY_DEPTH-1 of them, and the distance check follows it
// before the pair is stored or refused. A query scans the table from its
// oldest entry, with a memory read and then a compare for each entry, and
// an interpolation then waits on the shift-subtract unit. The next item is
// taken while a result beat still waits on the output register. No clearing
// pass is needed after reset.

module timestamp_sync_interpolator
   import tsi_pkg::*;
#(
   parameter int TABLE_DEPTH   = 100,
   parameter int HISTORY_DEPTH = 10,
   parameter int TIME_BITS     = 40
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: device_time_us, host_time_us
   input  logic [((2*TIME_BITS+7)/8)*8-1:0]   req_tdata,
   // tuser: func
   input  logic                               req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: corrected_time_us
   output logic [((TIME_BITS+7)/8)*8-1:0]     rsp_tdata,
   // tuser: status
   output logic [STATUS_BITS-1:0]             rsp_tuser,
   // register writes
   input  logic                               csr_we,
   input  logic [CSR_ADDR_W-1:0]              csr_addr,
   input  logic [CFG_BITS-1:0]                csr_wdata
);

   localparam int T       = TIME_BITS;
   localparam int D       = TABLE_DEPTH;
   localparam int H       = HISTORY_DEPTH;
   localparam int PTR_W   = $clog2(D);
   localparam int CNT_W   = $clog2(D + 1);
   localparam int HIDX_W  = $clog2(H);
   localparam int DCNT_W  = $clog2(H + 1);
   localparam int MED_RANK = (H - 1) / 2;
   localparam int RSP_W   = ((T + 7) / 8) * 8;

   // state and payload registers
   state_type               state_ff, state_in;
   logic                    func_ff;
   logic [T-1:0]            dev_ff, host_ff;
   logic signed [T:0]       delay_ff;
   logic [CFG_BITS-1:0]     tol_ff, gap_ff;
   logic [WARM_BITS-1:0]    warm_cfg_ff;
   logic [WARM_BITS-1:0]    warm_seen_ff, warm_seen_in;
   logic [T-1:0]            last_dev_ff, last_dev_in;
   logic                    last_valid_ff, last_valid_in;
   logic [CNT_W-1:0]        tcount_ff, tcount_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [DCNT_W-1:0]       dcount_ff, dcount_in;
   logic [HIDX_W-1:0]       cand_ff, cand_in;
   logic signed [T:0]       est_ff, est_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [T-1:0]            prev_dev_ff, prev_dev_in;
   logic [T-1:0]            prev_host_ff, prev_host_in;
   logic                    neg_ff, neg_in;
   logic [T-1:0]            res_time_ff, res_time_in;
   logic [STATUS_BITS-1:0]  res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [T-1:0]            rsp_time_ff, rsp_time_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;

   // datapath strobes
   logic                    ram_we;
   logic [PTR_W-1:0]        ram_waddr, ram_raddr;
   logic [2*T-1:0]          ram_rdata;
   logic                    div_start, div_done;
   logic [T-1:0]            div_m, div_a, div_b, div_res;
   cell_ctrl_type           cell_ctrl [H];
   logic signed [T:0]       cell_val [H];
   logic [H-1:0]            cell_lt, cell_eq;
   logic signed [T:0]       cand_val;

   // status flags
   logic                    accept, in_warm, jump, hist_full;
   logic [HIDX_W-1:0]       lt_cnt, eq_cnt;
   logic [HIDX_W:0]         lteq_cnt;
   logic                    med_hit;
   logic signed [T+1:0]     dist_s;
   logic [T+1:0]            dist_abs;
   logic                    dist_fault;
   logic [T-1:0]            ent_dev, ent_host, ent_gap;
   logic                    later, gap_bad, first_ent, last_ent, out_free;
   logic [PTR_W-1:0]        km1;

   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] x,
                                                input logic [PTR_W-1:0] y);
      logic [PTR_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= (PTR_W+1)'(D)) begin
         s = s - (PTR_W+1)'(D);
      end
      return s[PTR_W-1:0];
   endfunction

   // delay history chain
   for (genvar i = 0; i < H; i++) begin : g_cell
      logic signed [T:0] next_v;
      if (i == H - 1) begin : g_end
         assign next_v = '0;
      end else begin : g_mid
         assign next_v = cell_val[i+1];
      end
      tsi_delay_cell #(.DW(T + 1)) u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl[i]),
         .next_val (next_v),
         .new_val  (delay_ff),
         .cand     (cand_val),
         .value    (cell_val[i]),
         .lt       (cell_lt[i]),
         .eq       (cell_eq[i])
      );
   end

   // rank of the candidate among the held delays, oldest dropped
   assign cand_val = cell_val[cand_ff];
   assign lt_cnt   = HIDX_W'($countones(cell_lt[H-2:0]));
   assign eq_cnt   = HIDX_W'($countones(cell_eq[H-2:0]));
   assign lteq_cnt = {1'b0, lt_cnt} + {1'b0, eq_cnt};
   assign med_hit  = (lt_cnt <= HIDX_W'(MED_RANK)) &&
                     (lteq_cnt > (HIDX_W+1)'(MED_RANK));

   // distance of the new delay from the median
   assign dist_s     = (T+2)'(est_ff) - (T+2)'(delay_ff);
   assign dist_abs   = dist_s[T+1] ? (T+2)'(-dist_s) : (T+2)'(dist_s);
   assign dist_fault = dist_abs > (T+2)'(tol_ff);

   // pair checks
   assign accept    = req_tvalid && (state_ff == S_IDLE);
   assign in_warm   = warm_seen_ff < warm_cfg_ff;
   assign jump      = last_valid_ff && (dev_ff < last_dev_ff);
   assign hist_full = dcount_ff >= DCNT_W'(H);

   // table scan compare
   assign ent_dev   = ram_rdata[T-1:0];
   assign ent_host  = ram_rdata[2*T-1:T];
   assign ent_gap   = ent_dev - dev_ff;
   assign later     = ent_dev > dev_ff;
   assign gap_bad   = ent_gap > T'(gap_ff);
   assign first_ent = k_ff == '0;
   assign last_ent  = (k_ff + 1'b1) == tcount_ff;
   assign km1       = PTR_W'(k_ff - 1'b1);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!func_ff) begin
               if (in_warm || jump) state_in = S_OUT;
               else if (hist_full)  state_in = S_MEDIAN;
               else                 state_in = S_COMMIT;
            end else begin
               if (tcount_ff == '0) state_in = S_OUT;
               else                 state_in = S_SCAN_RD;
            end
         end
         S_MEDIAN: begin
            if (med_hit) state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = dist_fault ? S_OUT : S_COMMIT;
         end
         S_COMMIT:  state_in = S_OUT;
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            if (later) begin
               state_in = (gap_bad || first_ent) ? S_OUT : S_DIV;
            end else begin
               state_in = last_ent ? S_OUT : S_SCAN_RD;
            end
         end
         S_DIV: begin
            if (div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and bookkeeping
   always_comb begin
      warm_seen_in  = warm_seen_ff;
      last_dev_in   = last_dev_ff;
      last_valid_in = last_valid_ff;
      tcount_in     = tcount_ff;
      head_in       = head_ff;
      dcount_in     = dcount_ff;
      cand_in       = cand_ff;
      est_in        = est_ff;
      k_in          = k_ff;
      prev_dev_in   = prev_dev_ff;
      prev_host_in  = prev_host_ff;
      neg_in        = neg_ff;
      res_time_in   = res_time_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_time_in   = rsp_time_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = head_ff;
      ram_raddr     = ptr_add(head_ff, PTR_W'(k_ff));
      div_start     = 1'b0;
      div_m         = (ent_host >= prev_host_ff) ? ent_host - prev_host_ff
                                                 : prev_host_ff - ent_host;
      div_a         = dev_ff - prev_dev_ff;
      div_b         = ent_dev - prev_dev_ff;
      for (int i = 0; i < H; i++) begin
         cell_ctrl[i] = '0;
      end
      unique case (state_ff)
         S_DECIDE: begin
            res_time_in = '0;
            if (!func_ff) begin
               if (in_warm) begin
                  warm_seen_in  = warm_seen_ff + 1'b1;
                  res_status_in = ST_WARMUP;
               end else if (jump) begin
                  tcount_in     = '0;
                  head_in       = '0;
                  dcount_in     = '0;
                  last_valid_in = 1'b0;
                  warm_seen_in  = '0;
                  res_status_in = ST_TIME_JUMP;
               end else if (hist_full) begin
                  // drop the oldest delay
                  for (int i = 0; i < H; i++) begin
                     cell_ctrl[i].shift = 1'b1;
                  end
                  dcount_in = DCNT_W'(H - 1);
                  cand_in   = '0;
               end
            end else begin
               res_status_in = ST_EMPTY;
               k_in          = '0;
            end
         end
         S_MEDIAN: begin
            if (med_hit) begin
               est_in = cand_val;
            end else begin
               cand_in = cand_ff + 1'b1;
            end
         end
         S_CHECK: begin
            if (dist_fault) begin
               tcount_in     = '0;
               head_in       = '0;
               dcount_in     = '0;
               last_valid_in = 1'b0;
               warm_seen_in  = '0;
               res_time_in   = '0;
               res_status_in = ST_DELAY;
            end
         end
         S_COMMIT: begin
            // store the pair, evicting the oldest when full
            ram_we = 1'b1;
            if (tcount_ff == CNT_W'(D)) begin
               ram_waddr = head_ff;
               head_in   = ptr_add(head_ff, PTR_W'(1));
            end else begin
               ram_waddr = ptr_add(head_ff, PTR_W'(tcount_ff));
               tcount_in = tcount_ff + 1'b1;
            end
            for (int i = 0; i < H; i++) begin
               cell_ctrl[i].load = dcount_ff[HIDX_W-1:0] == HIDX_W'(i);
            end
            dcount_in     = dcount_ff + 1'b1;
            last_dev_in   = dev_ff;
            last_valid_in = 1'b1;
            res_time_in   = host_ff;
            res_status_in = ST_OK;
         end
         S_SCAN_CMP: begin
            if (later) begin
               neg_in = ent_host < prev_host_ff;
               if (gap_bad) begin
                  res_status_in = ST_GAP;
               end else if (first_ent) begin
                  res_status_in = ST_BEFORE;
               end else begin
                  div_start = 1'b1;
               end
            end else begin
               prev_dev_in   = ent_dev;
               prev_host_in  = ent_host;
               k_in          = k_ff + 1'b1;
               res_status_in = ST_NO_LATER;
            end
         end
         S_DIV: begin
            if (div_done) begin
               res_time_in   = neg_ff ? prev_host_ff - div_res : prev_host_ff + div_res;
               res_status_in = ST_OK;
               head_in       = ptr_add(head_ff, km1);
               tcount_in     = tcount_ff - CNT_W'(km1);
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_time_in   = res_time_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         warm_seen_ff  <= '0;
         last_valid_ff <= 1'b0;
         tcount_ff     <= '0;
         head_ff       <= '0;
         dcount_ff     <= '0;
         cand_ff       <= '0;
         k_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         warm_seen_ff  <= warm_seen_in;
         last_valid_ff <= last_valid_in;
         tcount_ff     <= tcount_in;
         head_ff       <= head_in;
         dcount_ff     <= dcount_in;
         cand_ff       <= cand_in;
         k_ff          <= k_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_tuser;
         dev_ff   <= req_tdata[T-1:0];
         host_ff  <= req_tdata[2*T-1:T];
         delay_ff <= (T+1)'($signed({1'b0, req_tdata[T-1:0]}) -
                            $signed({1'b0, req_tdata[2*T-1:T]}));
      end
      last_dev_ff   <= last_dev_in;
      est_ff        <= est_in;
      prev_dev_ff   <= prev_dev_in;
      prev_host_ff  <= prev_host_in;
      neg_ff        <= neg_in;
      res_time_ff   <= res_time_in;
      res_status_ff <= res_status_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_status_ff <= rsp_status_in;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff      <= TOL_RESET;
         gap_ff      <= GAP_RESET;
         warm_cfg_ff <= WARM_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CFG_DELAY_TOL: tol_ff      <= csr_wdata;
            CFG_MAX_GAP:   gap_ff      <= csr_wdata;
            CFG_WARMUP:    warm_cfg_ff <= csr_wdata[WARM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // pair table
   tsi_ram #(.WIDTH(2 * T), .DEPTH(D)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({host_ff, dev_ff}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // interpolation unit
   tsi_muldiv #(.W(T)) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .m      (div_m),
      .a      (div_a),
      .b      (div_b),
      .done   (div_done),
      .result (div_res)
   );

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_time_ff);
   assign rsp_tuser  = rsp_status_ff;

   // table and history never overfill
   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      tcount_ff <= CNT_W'(D))
      else $error("table count above depth");

   a_hist_bound: assert property (@(posedge clock) disable iff (reset)
      dcount_ff <= DCNT_W'(H))
      else $error("delay count above depth");

   // a stored pair leaves a non-empty table and a valid last time
   a_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT) |=> (tcount_ff != '0) && last_valid_ff)
      else $error("pair stored without table update");

   // the unit only finishes while a query waits on it
   a_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("interpolation finished outside query");

endmodule
